// ===== hw/rtl/btr_pkg.sv =====
// btr_pkg: types, codes and character tables for the token recognizer
// no dependencies
`timescale 1ns / 1ps

package btr_pkg;

    typedef enum logic [1:0] {
        MODE_REQ  = 2'd0,
        MODE_CHAR = 2'd1,
        MODE_DROP = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_BYTE      = 3'd0,
        ST_MATCH     = 3'd1,
        ST_NO_MATCH  = 3'd2,
        ST_NAME_FULL = 3'd3,
        ST_TRACE_OVF = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FEED_GO   = 2'd0,
        FEED_GOT  = 2'd1,
        FEED_NONE = 2'd2,
        FEED_FULL = 2'd3
    } t_feed_code;

    typedef enum logic [1:0] {
        FMT_DEC = 2'd0,
        FMT_HEX = 2'd1,
        FMT_BIN = 2'd2,
        FMT_OCT = 2'd3
    } t_fmt;

    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_SYMBOL  = 5'd1;
    localparam logic [4:0] KIND_NUMBER  = 5'd2;
    localparam logic [4:0] KIND_STRING  = 5'd3;
    localparam logic [4:0] KIND_CHAR    = 5'd4;
    localparam logic [4:0] KIND_COMMENT = 5'd5;
    localparam logic [4:0] KIND_LINE    = 5'd6;
    localparam logic [4:0] KIND_SHL     = 5'd7;
    localparam logic [4:0] KIND_SHR     = 5'd8;
    localparam logic [4:0] KIND_OP_LO   = 5'd9;
    localparam logic [4:0] KIND_OP_HI   = 5'd28;

    localparam int LEN_W = 7;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] token_type;
        logic       from_current;
        logic [7:0] char_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       name_byte;
        logic [2:0]       status;
        logic [LEN_W-1:0] token_length;
        logic             last;
    } t_out_item;

    typedef struct packed {
        t_feed_code code;
        logic       blank_inc;
        logic       tok_inc;
        logic       put;
        logic [7:0] put_byte;
        logic       esc;
        t_fmt       fmt;
    } t_feed;

    function automatic logic [7:0] op_char(input logic [4:0] kind);
        logic [7:0] c;
        case (kind)
            5'd9:    c = "~";
            5'd10:   c = "*";
            5'd11:   c = "/";
            5'd12:   c = "%";
            5'd13:   c = "&";
            5'd14:   c = "^";
            5'd15:   c = "|";
            5'd16:   c = "-";
            5'd17:   c = "+";
            5'd18:   c = ".";
            5'd19:   c = "=";
            5'd20:   c = ",";
            5'd21:   c = "#";
            5'd22:   c = ":";
            5'd23:   c = "{";
            5'd24:   c = "}";
            5'd25:   c = "[";
            5'd26:   c = "]";
            5'd27:   c = "(";
            5'd28:   c = ")";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c == "_") || (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "n":     r = 8'd10;
            "r":     r = 8'd13;
            "0":     r = 8'd0;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/btr_match.sv =====
// btr_match: one character step of the token matcher
// depends on btr_pkg
`timescale 1ns / 1ps

module btr_match
    import btr_pkg::*;
#(
    parameter int NAME_MAX = 32,
    parameter int CW       = 7,
    parameter int PW       = 6
) (
    input  logic [7:0]    i_char,
    input  logic [4:0]    i_kind,
    input  logic [CW-1:0] i_tok,
    input  logic [PW-1:0] i_pay,
    input  logic          i_esc,
    input  t_fmt          i_fmt,
    output t_feed         o_feed
);

    logic tok0;
    logic ok;

    assign tok0 = (i_tok == '0);

    always_comb begin
        o_feed           = '0;
        o_feed.code      = FEED_GO;
        o_feed.put_byte  = i_char;
        o_feed.esc       = i_esc;
        o_feed.fmt       = i_fmt;
        ok               = 1'b0;
        if (i_pay >= PW'(NAME_MAX)) begin
            o_feed.code = FEED_FULL;
        end else if (tok0 && (i_char == " " || i_char == 8'd9 || i_char == 8'd13)) begin
            o_feed.blank_inc = 1'b1;
        end else if (i_kind == KIND_SYMBOL) begin
            if (tok0 && !is_alpha(i_char)) begin
                o_feed.code = FEED_NONE;
            end else if (!tok0 && !is_alpha(i_char) && !is_digit(i_char)) begin
                o_feed.code = FEED_GOT;
            end else begin
                o_feed.put     = 1'b1;
                o_feed.tok_inc = 1'b1;
            end
        end else if (i_kind == KIND_NUMBER) begin
            if (tok0) begin
                o_feed.put     = 1'b1;
                o_feed.tok_inc = 1'b1;
                if (i_char == "$") begin
                    o_feed.fmt = FMT_HEX;
                end else if (i_char == "%") begin
                    o_feed.fmt = FMT_BIN;
                end else if (i_char == "@") begin
                    o_feed.fmt = FMT_OCT;
                end else if (is_digit(i_char)) begin
                    o_feed.fmt = FMT_DEC;
                end else begin
                    o_feed.put     = 1'b0;
                    o_feed.tok_inc = 1'b0;
                    o_feed.code    = FEED_NONE;
                end
            end else if (i_char == "_") begin
                o_feed.tok_inc = 1'b1;
            end else begin
                case (i_fmt)
                    FMT_HEX: ok = is_digit(i_char) || (i_char inside {["a":"f"]})
                                  || (i_char inside {["A":"F"]});
                    FMT_BIN: ok = (i_char == "0") || (i_char == "1");
                    FMT_OCT: ok = i_char inside {["0":"7"]};
                    default: ok = is_digit(i_char);
                endcase
                if (ok) begin
                    o_feed.put     = 1'b1;
                    o_feed.tok_inc = 1'b1;
                end else begin
                    o_feed.code = FEED_GOT;
                end
            end
        end else if (i_kind == KIND_STRING) begin
            o_feed.tok_inc = 1'b1;
            if (tok0) begin
                if (i_char != 8'h22) begin
                    o_feed.code    = FEED_NONE;
                    o_feed.tok_inc = 1'b0;
                end
            end else if (i_esc) begin
                o_feed.put      = 1'b1;
                o_feed.put_byte = unescape(i_char);
                o_feed.esc      = 1'b0;
            end else if (i_char == 8'h5c) begin
                o_feed.esc = 1'b1;
            end else if (i_char == 8'h22) begin
                o_feed.code = FEED_GOT;
            end else begin
                o_feed.put = 1'b1;
            end
        end else if (i_kind == KIND_CHAR) begin
            o_feed.tok_inc = 1'b1;
            if (tok0) begin
                if (i_char != 8'h27) begin
                    o_feed.code    = FEED_NONE;
                    o_feed.tok_inc = 1'b0;
                end
            end else if (i_pay != '0) begin
                if (i_char != 8'h27) begin
                    o_feed.code    = FEED_NONE;
                    o_feed.tok_inc = 1'b0;
                end else begin
                    o_feed.code = FEED_GOT;
                end
            end else if (i_esc) begin
                o_feed.put      = 1'b1;
                o_feed.put_byte = unescape(i_char);
                o_feed.esc      = 1'b0;
            end else if (i_char == 8'h5c) begin
                o_feed.esc = 1'b1;
            end else begin
                o_feed.put = 1'b1;
            end
        end else if (i_kind == KIND_COMMENT) begin
            if (i_char == 8'd10) begin
                o_feed.put     = 1'b1;
                o_feed.tok_inc = 1'b1;
                o_feed.code    = FEED_GOT;
            end else if (tok0 && i_char != ";") begin
                o_feed.code = FEED_NONE;
            end else begin
                o_feed.put     = 1'b1;
                o_feed.tok_inc = 1'b1;
            end
        end else if (i_kind == KIND_LINE) begin
            o_feed.put     = 1'b1;
            o_feed.tok_inc = 1'b1;
            if (i_char == 8'd10) begin
                o_feed.code = FEED_GOT;
            end
        end else if (i_kind == KIND_SHL || i_kind == KIND_SHR) begin
            if (i_char != ((i_kind == KIND_SHL) ? 8'h3c : 8'h3e)) begin
                o_feed.code = FEED_NONE;
            end else begin
                o_feed.put     = 1'b1;
                o_feed.tok_inc = 1'b1;
                if (i_pay == PW'(1)) begin
                    o_feed.code = FEED_GOT;
                end
            end
        end else if (i_kind >= KIND_OP_LO && i_kind <= KIND_OP_HI) begin
            if (i_char == op_char(i_kind)) begin
                o_feed.put     = 1'b1;
                o_feed.tok_inc = 1'b1;
                o_feed.code    = FEED_GOT;
            end else begin
                o_feed.code = FEED_NONE;
            end
        end else begin
            o_feed.code = FEED_NONE;
        end
    end

endmodule

// ===== hw/rtl/backtracking_token_recognizer.sv =====
// backtracking_token_recognizer: top level with trace ring, name store and control
// depends on btr_pkg and btr_match
`timescale 1ns / 1ps

// Takes one item at a time. A character item is handled directly in the idle
// state. A token request replays characters from the trace ring, each through a
// ring memory read then a match step, up to TRACE_DEPTH characters. When a token
// ends, the result phase delivers the name bytes on a match, each read from the
// name store and then presented, and then the final status, each held until the
// receiver takes it. No input is taken while results are being delivered.

module backtracking_token_recognizer
    import btr_pkg::*;
#(
    parameter int TRACE_DEPTH = 64,
    parameter int NAME_MAX    = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_out
);

    localparam int AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
    localparam int CW = $clog2(TRACE_DEPTH + 1);
    localparam int NW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int PW = $clog2(NAME_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_FEED, S_NRD, S_NOUT, S_STAT
    } t_state;

    t_state r_state, n_state;

    logic [7:0] r_ring [TRACE_DEPTH];
    logic [7:0] r_name [NAME_MAX];
    logic [7:0] r_ring_q;
    logic [7:0] r_name_q;

    logic [AW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_look, n_look;
    logic [CW-1:0] r_replay, n_replay;
    logic          r_active, n_active;
    logic [4:0]    r_kind, n_kind;
    logic [CW-1:0] r_tok, n_tok;
    logic [PW-1:0] r_pay, n_pay;
    logic [CW-1:0] r_blank, n_blank;
    logic          r_esc, n_esc;
    t_fmt          r_fmt, n_fmt;
    logic          r_rewind, n_rewind;
    logic [PW-1:0] r_idx, n_idx;
    t_status       r_fin, n_fin;
    logic [LEN_W-1:0] r_out_len, n_out_len;

    logic          ring_we;
    logic          name_we;
    logic          do_feed;
    logic [7:0]    feed_char;
    t_feed         feed;
    logic          fin;
    logic          fin_got;
    t_status       fin_code;
    logic [CW:0]   total;
    logic [CW:0]   used;
    logic [CW:0]   pos_sum;
    logic [AW-1:0] rd_pos;

    btr_match #(
        .NAME_MAX (NAME_MAX),
        .CW       (CW),
        .PW       (PW)
    ) u_match (
        .i_char (feed_char),
        .i_kind (r_kind),
        .i_tok  (r_tok),
        .i_pay  (r_pay),
        .i_esc  (r_esc),
        .i_fmt  (r_fmt),
        .o_feed (feed)
    );

    // ring position of the next replayed character
    always_comb begin
        pos_sum = {1'b0, CW'(r_wp)} + (CW + 1)'(TRACE_DEPTH) - {1'b0, r_replay};
        if (pos_sum >= (CW + 1)'(TRACE_DEPTH)) begin
            pos_sum = pos_sum - (CW + 1)'(TRACE_DEPTH);
        end
        rd_pos = pos_sum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wp] <= i_in.char_byte;
        end
        r_ring_q <= r_ring[rd_pos];
    end

    always_ff @(posedge i_clk) begin
        if (name_we) begin
            r_name[r_pay[NW-1:0]] <= feed.put_byte;
        end
        r_name_q <= r_name[r_idx[NW-1:0]];
    end

    // datapath next values
    always_comb begin
        n_wp      = r_wp;
        n_cur     = r_cur;
        n_look    = r_look;
        n_replay  = r_replay;
        n_active  = r_active;
        n_kind    = r_kind;
        n_tok     = r_tok;
        n_pay     = r_pay;
        n_blank   = r_blank;
        n_esc     = r_esc;
        n_fmt     = r_fmt;
        n_rewind  = r_rewind;
        n_idx     = r_idx;
        n_fin     = r_fin;
        n_out_len = r_out_len;
        ring_we   = 1'b0;
        name_we   = 1'b0;
        do_feed   = 1'b0;
        feed_char = r_ring_q;
        fin       = 1'b0;
        fin_code  = ST_NO_MATCH;
        total     = '0;
        used      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_mode'(i_in.mode))
                        MODE_REQ: begin
                            n_kind   = i_in.token_type;
                            n_rewind = i_in.from_current;
                            total    = i_in.from_current ? ({1'b0, r_cur} + {1'b0, r_look})
                                                         : {1'b0, r_look};
                            n_replay = (total > (CW + 1)'(TRACE_DEPTH)) ? CW'(TRACE_DEPTH)
                                                                        : total[CW-1:0];
                            n_tok    = '0;
                            n_pay    = '0;
                            n_blank  = '0;
                            n_esc    = 1'b0;
                            n_fmt    = FMT_DEC;
                            n_active = 1'b1;
                        end
                        MODE_CHAR: begin
                            if (r_active) begin
                                if (i_in.end_of_file) begin
                                    fin      = 1'b1;
                                    fin_code = (r_kind == KIND_EOF) ? ST_MATCH : ST_NO_MATCH;
                                end else if ({1'b0, r_cur} + {1'b0, r_look}
                                             >= (CW + 1)'(TRACE_DEPTH)) begin
                                    fin      = 1'b1;
                                    fin_code = ST_TRACE_OVF;
                                end else begin
                                    ring_we   = 1'b1;
                                    n_wp      = (r_wp == AW'(TRACE_DEPTH - 1)) ? '0
                                                                              : r_wp + 1'b1;
                                    n_look    = r_look + 1'b1;
                                    do_feed   = 1'b1;
                                    feed_char = i_in.char_byte;
                                end
                            end
                        end
                        MODE_DROP: begin
                            if (!r_active) begin
                                n_cur = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FEED: begin
                n_replay = r_replay - 1'b1;
                do_feed  = 1'b1;
            end
            S_NOUT: begin
                if (i_ready) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: ;
        endcase

        if (do_feed) begin
            if (feed.blank_inc) begin
                n_blank = r_blank + 1'b1;
            end
            if (feed.tok_inc) begin
                n_tok = r_tok + 1'b1;
            end
            if (feed.put) begin
                name_we = 1'b1;
                n_pay   = r_pay + 1'b1;
            end
            n_esc = feed.esc;
            n_fmt = feed.fmt;
            case (feed.code)
                FEED_GOT: begin
                    fin      = 1'b1;
                    fin_code = ST_MATCH;
                end
                FEED_NONE: begin
                    fin      = 1'b1;
                    fin_code = ST_NO_MATCH;
                end
                FEED_FULL: begin
                    fin      = 1'b1;
                    fin_code = ST_NAME_FULL;
                end
                default: ;
            endcase
        end

        fin_got = fin && (fin_code == ST_MATCH);
        if (fin) begin
            n_active  = 1'b0;
            n_replay  = '0;
            n_fin     = fin_code;
            n_idx     = '0;
            n_out_len = fin_got ? LEN_W'(n_tok) : '0;
            if (fin_got) begin
                total  = r_rewind ? ({1'b0, r_cur} + {1'b0, n_look}) : {1'b0, n_look};
                used   = {1'b0, n_tok} + {1'b0, n_blank};
                n_cur  = n_tok;
                n_look = (total >= used) ? CW'(total - used) : '0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (fin) begin
                    n_state = (fin_got && n_pay != '0) ? S_NRD : S_STAT;
                end else if (i_valid && t_mode'(i_in.mode) == MODE_REQ && n_replay != '0) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_FEED;
            end
            S_FEED: begin
                if (fin) begin
                    n_state = (fin_got && n_pay != '0) ? S_NRD : S_STAT;
                end else if (r_replay == CW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_NRD: begin
                n_state = S_NOUT;
            end
            S_NOUT: begin
                if (i_ready) begin
                    n_state = (r_idx + 1'b1 == r_pay) ? S_STAT : S_NRD;
                end
            end
            S_STAT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_NOUT) || (r_state == S_STAT);
        o_out   = '0;
        if (r_state == S_NOUT) begin
            o_out.name_byte = r_name_q;
            o_out.status    = ST_BYTE;
        end else begin
            o_out.status       = r_fin;
            o_out.token_length = r_out_len;
            o_out.last         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_cur    <= '0;
            r_look   <= '0;
            r_replay <= '0;
            r_active <= 1'b0;
            r_kind   <= '0;
            r_tok    <= '0;
            r_pay    <= '0;
            r_blank  <= '0;
            r_esc    <= 1'b0;
            r_fmt    <= FMT_DEC;
            r_rewind <= 1'b0;
            r_idx    <= '0;
            r_fin    <= ST_NO_MATCH;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_cur    <= n_cur;
            r_look   <= n_look;
            r_replay <= n_replay;
            r_active <= n_active;
            r_kind   <= n_kind;
            r_tok    <= n_tok;
            r_pay    <= n_pay;
            r_blank  <= n_blank;
            r_esc    <= n_esc;
            r_fmt    <= n_fmt;
            r_rewind <= n_rewind;
            r_idx    <= n_idx;
            r_fin    <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_len <= n_out_len;
    end

endmodule

// ===== hw/rtl/btr_checker.sv =====
// btr_checker: port level checks for the token recognizer, bound to the top level
// depends on btr_pkg
`timescale 1ns / 1ps

module btr_checker
    import btr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_in,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_out
);

    // pending result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("result changed before transfer");

    // no input taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    // only status results end a request
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out.status == ST_BYTE) == !o_out.last))
        else $error("last flag does not match status");

    // status results carry no name byte
    a_status_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status != ST_BYTE |-> o_out.name_byte == 8'd0)
        else $error("status result with name byte");

endmodule

bind backtracking_token_recognizer btr_checker u_btr_checker (.*);
